// ===== src/krt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and codes for the keyed record table: operation and status
// codes, the controller state type and the probe that walks the cell chain.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int KEY_W    = 32;
    localparam int GRADE_W  = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    // Operation codes carried on the kind field
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_UPDATE = 2'd2
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOTFOUND  = 3'd4,
        ST_UPDATED   = 3'd5
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_WALK,
        CTL_HOLD
    } t_ctl_state;

    // Probe that moves one cell per cycle along the chain
    typedef struct packed {
        logic                      vld;    // probe present in this stage
        logic [KIND_W-1:0]         kind;   // raw operation code
        logic signed [KEY_W-1:0]   key;    // key being searched
        logic [GRADE_W-1:0]        grade;  // grade to insert or update
        logic                      hit;    // an earlier cell held the key
        logic                      ins;    // an earlier cell took the insert
        logic [GRADE_W-1:0]        rgrade; // grade read on a lookup hit
    } t_probe;

endpackage

// ===== src/krt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_cell
// One table entry. Compares the passing probe with its stored key, takes an
// appended record or a grade update, and forwards the probe one stage on.
// ----------------------------------------------------------------------------
module krt_cell #(
    parameter int CELL_IDX = 0,
    parameter int SLOT_W   = 4,
    parameter int CNT_W    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CNT_W-1:0]     i_count,
    input  krt_pkg::t_probe      i_probe,
    input  logic [SLOT_W-1:0]    i_slot,
    output krt_pkg::t_probe      o_probe,
    output logic [SLOT_W-1:0]    o_slot
);

    logic signed [krt_pkg::KEY_W-1:0] r_key;
    logic [krt_pkg::GRADE_W-1:0]      r_grade;
    krt_pkg::t_probe                  r_probe;
    krt_pkg::t_probe                  n_probe;
    logic [SLOT_W-1:0]                r_slot;
    logic [SLOT_W-1:0]                n_slot;
    logic                             w_written;
    logic                             w_searched;
    logic                             w_match;
    logic                             w_append;

    // Only entries below the fill count hold a record
    assign w_written  = CNT_W'(CELL_IDX) < i_count;
    assign w_searched = (i_probe.kind == krt_pkg::KIND_INSERT)
                     || (i_probe.kind == krt_pkg::KIND_LOOKUP)
                     || (i_probe.kind == krt_pkg::KIND_UPDATE);
    assign w_match    = i_probe.vld && !i_probe.hit && !i_probe.ins && w_searched
                     && w_written && (r_key == i_probe.key);
    // The first free entry takes an insert that met no duplicate
    assign w_append   = i_probe.vld && !i_probe.hit && !i_probe.ins
                     && (i_probe.kind == krt_pkg::KIND_INSERT)
                     && (CNT_W'(CELL_IDX) == i_count);

    // Mark the probe on a hit or an append
    always_comb begin
        n_probe = i_probe;
        n_slot  = i_slot;
        if (w_match) begin
            n_probe.hit = 1'b1;
            n_slot      = SLOT_W'(CELL_IDX);
            if (i_probe.kind == krt_pkg::KIND_LOOKUP) begin
                n_probe.rgrade = r_grade;
            end
        end else if (w_append) begin
            n_probe.ins = 1'b1;
            n_slot      = SLOT_W'(CELL_IDX);
        end
    end

    // Write the entry on append or update
    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_key   <= i_probe.key;
            r_grade <= i_probe.grade;
        end else if (w_match && (i_probe.kind == krt_pkg::KIND_UPDATE)) begin
            r_grade <= i_probe.grade;
        end
    end

    // Advance the probe one stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.vld <= 1'b0;
        end else begin
            r_probe.vld <= n_probe.vld;
        end
        r_probe.kind   <= n_probe.kind;
        r_probe.key    <= n_probe.key;
        r_probe.grade  <= n_probe.grade;
        r_probe.hit    <= n_probe.hit;
        r_probe.ins    <= n_probe.ins;
        r_probe.rgrade <= n_probe.rgrade;
        r_slot         <= n_slot;
    end

    assign o_probe = r_probe;
    assign o_slot  = r_slot;

endmodule

// ===== src/keyed_record_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table
// Content-searched table of key/grade records built as a chain of cells.
// Each operation enters the chain as a probe and visits one entry per cycle.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_ready    i_kind, i_key, i_grade
//   out      from block o_out_valid / i_out_ready  o_status, o_stored_grade,
//                                                  o_slot, o_entries_used
//
// One operation at a time: the probe walks the cell chain, waits in the
// result register while the output register is busy, then moves to the
// output register. The input is ready again in the same cycle the result
// shows there.
// The next item is taken as soon as the result reaches the output register,
// even while that result waits on i_out_ready.
// Reset clears the fill count and control state; stores need no clearing.
// ----------------------------------------------------------------------------
module keyed_record_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [krt_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [krt_pkg::KEY_W-1:0]   i_key,
    input  logic [krt_pkg::GRADE_W-1:0]        i_grade,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [krt_pkg::STATUS_W-1:0]       o_status,
    output logic [krt_pkg::GRADE_W-1:0]        o_stored_grade,
    output logic [SLOT_W-1:0]                  o_slot,
    output logic [CNT_W-1:0]                   o_entries_used
);

    krt_pkg::t_ctl_state r_state;
    krt_pkg::t_ctl_state n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    krt_pkg::t_probe     w_probe [TABLE_DEPTH+1];
    logic [SLOT_W-1:0]   w_slot  [TABLE_DEPTH+1];
    krt_pkg::t_probe     w_tail;
    logic                w_in_xfer;
    logic                w_move;

    logic [krt_pkg::STATUS_W-1:0] n_status;
    logic [krt_pkg::GRADE_W-1:0]  n_sgrade;
    logic [SLOT_W-1:0]            n_slot;

    logic [krt_pkg::STATUS_W-1:0] r_res_status;
    logic [krt_pkg::GRADE_W-1:0]  r_res_sgrade;
    logic [SLOT_W-1:0]            r_res_slot;
    logic [CNT_W-1:0]             r_res_used;

    logic                         r_out_vld;
    logic [krt_pkg::STATUS_W-1:0] r_out_status;
    logic [krt_pkg::GRADE_W-1:0]  r_out_sgrade;
    logic [SLOT_W-1:0]            r_out_slot;
    logic [CNT_W-1:0]             r_out_used;

    // Launch a fresh probe into the head of the chain
    assign w_in_xfer = i_in_valid && o_in_ready;

    // Fields in order: vld, kind, key, grade, hit, ins, rgrade
    assign w_probe[0] = {w_in_xfer, i_kind, i_key, i_grade, 1'b0, 1'b0,
                         {krt_pkg::GRADE_W{1'b0}}};
    assign w_slot[0]  = '0;

    // Cell chain, one entry per cell
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        krt_cell #(
            .CELL_IDX (g),
            .SLOT_W   (SLOT_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_count),
            .i_probe (w_probe[g]),
            .i_slot  (w_slot[g]),
            .o_probe (w_probe[g+1]),
            .o_slot  (w_slot[g+1])
        );
    end

    assign w_tail = w_probe[TABLE_DEPTH];

    // Turn the finished probe into a status
    always_comb begin
        n_status = krt_pkg::ST_NOTFOUND;
        n_sgrade = '0;
        n_slot   = '0;
        unique case (w_tail.kind)
            krt_pkg::KIND_INSERT: begin
                if (w_tail.ins) begin
                    n_status = krt_pkg::ST_INSERTED;
                    n_slot   = w_slot[TABLE_DEPTH];
                end else if (w_tail.hit) begin
                    n_status = krt_pkg::ST_DUPLICATE;
                    n_slot   = w_slot[TABLE_DEPTH];
                end else begin
                    n_status = krt_pkg::ST_FULL;
                end
            end
            krt_pkg::KIND_LOOKUP: begin
                if (w_tail.hit) begin
                    n_status = krt_pkg::ST_FOUND;
                    n_sgrade = w_tail.rgrade;
                    n_slot   = w_slot[TABLE_DEPTH];
                end
            end
            krt_pkg::KIND_UPDATE: begin
                if (w_tail.hit) begin
                    n_status = krt_pkg::ST_UPDATED;
                    n_slot   = w_slot[TABLE_DEPTH];
                end
            end
            default: begin
                n_status = krt_pkg::ST_NOTFOUND;
            end
        endcase
    end

    // Bump the fill count when an append completes
    assign n_count = (w_tail.vld && w_tail.ins) ? r_count + CNT_W'(1) : r_count;

    // Controller next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            krt_pkg::CTL_IDLE: if (w_in_xfer)   n_state = krt_pkg::CTL_WALK;
            krt_pkg::CTL_WALK: if (w_tail.vld)  n_state = krt_pkg::CTL_HOLD;
            krt_pkg::CTL_HOLD: if (w_move)      n_state = krt_pkg::CTL_IDLE;
            default:                            n_state = krt_pkg::CTL_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_move     = 1'b0;
        unique case (r_state)
            krt_pkg::CTL_IDLE: o_in_ready = 1'b1;
            krt_pkg::CTL_WALK: o_in_ready = 1'b0;
            krt_pkg::CTL_HOLD: w_move     = !r_out_vld || i_out_ready;
            default:           o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krt_pkg::CTL_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Hold the result while the output register is busy
    always_ff @(posedge i_clk) begin
        if (w_tail.vld) begin
            r_res_status <= n_status;
            r_res_sgrade <= n_sgrade;
            r_res_slot   <= n_slot;
            r_res_used   <= n_count;
        end
    end

    // Output register: load on move, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_move) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_status <= r_res_status;
            r_out_sgrade <= r_res_sgrade;
            r_out_slot   <= r_res_slot;
            r_out_used   <= r_res_used;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out_status;
    assign o_stored_grade = r_out_sgrade;
    assign o_slot         = r_out_slot;
    assign o_entries_used = r_out_used;

endmodule

// ===== src/krt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_checker
// Port-level checks on the keyed record table, bound to the top level.
// ----------------------------------------------------------------------------
module krt_checker #(
    parameter int TABLE_DEPTH = 16,
    parameter int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic [krt_pkg::STATUS_W-1:0]       o_status,
    input  logic [krt_pkg::GRADE_W-1:0]        o_stored_grade,
    input  logic [SLOT_W-1:0]                  o_slot,
    input  logic [CNT_W-1:0]                   o_entries_used
);

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // Take one operation at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second operation taken while one is in flight");

    // Never report more entries than the table holds
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entries_used <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // Report a grade only on a lookup hit
    a_grade_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != krt_pkg::ST_FOUND) |-> o_stored_grade == '0)
        else $error("grade reported without a lookup hit");

    // Report slot zero when no entry was matched or written
    a_slot_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == krt_pkg::ST_FULL)
                     || (o_status == krt_pkg::ST_NOTFOUND)) |-> o_slot == '0)
        else $error("slot reported without an entry");

endmodule

bind keyed_record_table krt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_krt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_stored_grade (o_stored_grade),
    .o_slot         (o_slot),
    .o_entries_used (o_entries_used)
);
